>>> rtl/core/cve_pkg.sv
// ----------------------------------------------------------------------------
// cve_pkg
// Shared types, constants and letter arithmetic for the CBC Vigenere encryptor.
// ----------------------------------------------------------------------------
`default_nettype none

package cve_pkg;

  // Fixed geometry of the key and IV registers: twelve 5-bit letter slots.
  localparam int unsigned SLOTS       = 12;
  localparam int unsigned LETTER_W    = 5;
  localparam int unsigned SLOT_IDX_W  = 4;
  localparam int unsigned LETTERS_W   = SLOTS * LETTER_W;
  localparam int unsigned LEN_W       = 4;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = LETTERS_W;
  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned SUM_W       = 7;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_LENGTH  = 2'd0,
    REG_KEY_LETTERS = 2'd1,
    REG_IV_LETTERS  = 2'd2
  } cfg_reg_e;

  localparam logic [CHAR_W-1:0] CHAR_UP_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UP_Z = 8'h5A;
  localparam logic [CHAR_W-1:0] CHAR_LO_A = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LO_Z = 8'h7A;
  localparam logic [CHAR_W-1:0] CHAR_PAD  = 8'h78;
  localparam logic [CHAR_W-1:0] CASE_GAP  = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_NONE = 8'h00;

  localparam logic [LETTER_W-1:0] ALPHA     = 5'd26;
  localparam logic [SUM_W-1:0]    ALPHA_S   = 7'd26;
  localparam logic [SUM_W-1:0]    ALPHA_2_S = 7'd52;

  // One letter to encrypt: slot index, plain letter and chain source.
  typedef struct packed {
    logic [SLOT_IDX_W-1:0] slot;
    logic [LETTER_W-1:0]   plain;
    logic                  use_iv;
    logic [LETTER_W-1:0]   chain;
  } cve_req_t;

  // Reduce a raw 5-bit letter code mod 26.
  function automatic logic [LETTER_W-1:0] fold26(input logic [LETTER_W-1:0] v);
    logic [LETTER_W-1:0] r;
    r = (v >= ALPHA) ? v - ALPHA : v;
    return r;
  endfunction

  // Reduce a sum of three letters (at most 75) mod 26.
  function automatic logic [LETTER_W-1:0] mod26_sum(input logic [SUM_W-1:0] s);
    logic [SUM_W-1:0] t;
    logic [SUM_W-1:0] u;
    t = (s >= ALPHA_2_S) ? s - ALPHA_2_S : s;
    u = (t >= ALPHA_S) ? t - ALPHA_S : t;
    return u[LETTER_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/cve_cipher_unit.sv
// ----------------------------------------------------------------------------
// cve_cipher_unit
// Combinational letter cipher: (plain + key[slot] + chain) mod 26.
// ----------------------------------------------------------------------------
`default_nettype none

module cve_cipher_unit (
  input  var cve_pkg::cve_req_t                 req_i,
  input  var logic [cve_pkg::LETTERS_W-1:0]     key_letters_i,
  input  var logic [cve_pkg::LETTERS_W-1:0]     iv_letters_i,
  output var logic [cve_pkg::LETTER_W-1:0]      cipher_o
);
  import cve_pkg::*;

  logic [LETTER_W-1:0] key_slots [SLOTS];
  logic [LETTER_W-1:0] iv_slots  [SLOTS];
  logic [LETTER_W-1:0] key_l;
  logic [LETTER_W-1:0] chain_l;
  logic [SUM_W-1:0]    sum;

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      key_slots[i] = key_letters_i[i*LETTER_W +: LETTER_W];
      iv_slots[i]  = iv_letters_i[i*LETTER_W +: LETTER_W];
    end
  end

  always_comb begin
    key_l    = fold26(key_slots[req_i.slot]);
    // first block chains from the IV, later blocks from stored ciphertext
    chain_l  = req_i.use_iv ? fold26(iv_slots[req_i.slot]) : fold26(req_i.chain);
    sum      = SUM_W'(req_i.plain) + SUM_W'(key_l) + SUM_W'(chain_l);
    cipher_o = mod26_sum(sum);
  end

endmodule

`default_nettype wire

>>> rtl/core/cbc_vigenere_encrypt_top.sv
// ----------------------------------------------------------------------------
// cbc_vigenere_encrypt_top
// CBC-mode Vigenere encryptor over a byte stream, one letter per beat.
//
// Bytes arrive on the input channel. Upper-case letters fold to lower case,
// all other non-letters are dropped without a result. A letter at block
// position j leaves as 'a' + (p + key[j] + chain[j]) mod 26, where chain[j]
// is the IV letter in the first block of a message and the ciphertext letter
// at position j of the previous block afterwards; the block length is the
// key length (0 reads as 1, values above KEY_MAX saturate). An end-of-text
// beat pads the open block with plain 'x' beats flagged is_pad, the final
// one flagged last; on a block boundary it gives a bare end marker
// (char_valid low, last high); an empty message gets a full block of pads.
// Throughput: letters and dropped bytes are taken at one per cycle while the
// output is not stalled; an end-of-text beat holds the cipher stage until
// every result it emits (up to the key length) has left, since every result
// leaves through the single output register. An accepted letter is
// registered in the cipher stage and then in the output register.
// The chain letters live in a KEY_MAX-entry memory with a registered read:
// the read is issued at accept, the new ciphertext is written back when the
// letter moves on to the output register, and a write to the entry being
// read in that same cycle is forwarded.
// Write configuration only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module cbc_vigenere_encrypt_top #(
  parameter int unsigned KEY_MAX = 12
) (
  input  var logic                              clk_i,
  input  var logic                              rst_ni,
  // configuration write port
  input  var logic                              cfg_we_i,
  input  var logic [cve_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  var logic [cve_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // input channel
  input  var logic                              in_valid_i,
  output var logic                              in_ready_o,
  input  var logic [7:0]                        in_byte_i,
  input  var logic                              end_of_text_i,
  // output channel
  output var logic                              out_valid_o,
  input  var logic                              out_ready_i,
  output var logic [7:0]                        out_char_o,
  output var logic                              char_valid_o,
  output var logic                              is_pad_o,
  output var logic                              last_o
);
  import cve_pkg::*;

  localparam int unsigned AW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(KEY_MAX);

  // Configuration registers
  logic [LEN_W-1:0]     key_len_q;
  logic [LETTERS_W-1:0] key_q;
  logic [LETTERS_W-1:0] iv_q;

  // Block tracking, updated at accept time
  logic [AW-1:0] pos_q, pos_d;
  logic          first_q, first_d;

  // Cipher stage: holds one letter in flight or one end-of-text beat
  logic                s1_v_q, s1_v_d;
  logic                s1_end_q, s1_end_d;
  logic                s1_bare_q, s1_bare_d;
  logic [AW-1:0]       s1_pos_q, s1_pos_d;
  logic                s1_first_q, s1_first_d;
  logic [LETTER_W-1:0] s1_p_q, s1_p_d;
  logic                s1_fwd_q, s1_fwd_d;

  // Chain memory and its read/forward registers
  logic [LETTER_W-1:0] chain_mem [KEY_MAX];
  logic [LETTER_W-1:0] rdata_q;
  logic [LETTER_W-1:0] lastc_q;

  // Output register
  logic              out_v_q, out_v_d;
  logic [CHAR_W-1:0] out_char_q, out_char_d;
  logic              out_cv_q, out_cv_d;
  logic              out_pad_q, out_pad_d;
  logic              out_last_q, out_last_d;

  logic [LEN_W-1:0]    len;
  logic                wrap;
  logic [AW-1:0]       pos_eff;
  logic                first_eff;
  logic [LEN_W-1:0]    pos_inc;
  logic                blk_end;
  logic [CHAR_W-1:0]   lower;
  logic                is_letter;
  logic [LETTER_W-1:0] plain;
  logic                accept;
  logic                take_letter;
  logic                s1_move;
  logic                s1_letter;
  logic                pad_last;
  logic                s1_done;
  logic                mem_we;
  cve_req_t            req;
  logic [LETTER_W-1:0] cipher;

  // --------------------------------------------------------------------------
  // Configuration: plain writes, no read-back; unknown indexes are dropped.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_len_q <= LEN_W'(1);
      key_q     <= '0;
      iv_q      <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_KEY_LENGTH:  key_len_q <= cfg_data_i[LEN_W-1:0];
        REG_KEY_LETTERS: key_q     <= cfg_data_i;
        REG_IV_LETTERS:  iv_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Block length: zero reads as one, saturate at KEY_MAX
  always_comb begin
    if (key_len_q == '0) begin
      len = LEN_W'(1);
    end else if (key_len_q > LEN_MAX) begin
      len = LEN_MAX;
    end else begin
      len = key_len_q;
    end
  end

  // --------------------------------------------------------------------------
  // Input decode and block position bookkeeping
  // --------------------------------------------------------------------------
  always_comb begin
    // a block left open by a shortened key counts as closed
    wrap      = LEN_W'(pos_q) >= len;
    pos_eff   = wrap ? '0 : pos_q;
    first_eff = wrap ? 1'b0 : first_q;
    pos_inc   = LEN_W'(pos_eff) + LEN_W'(1);
    blk_end   = pos_inc >= len;

    lower     = (in_byte_i >= CHAR_UP_A && in_byte_i <= CHAR_UP_Z) ?
                in_byte_i + CASE_GAP : in_byte_i;
    is_letter = (lower >= CHAR_LO_A) && (lower <= CHAR_LO_Z);
    plain     = LETTER_W'(lower - CHAR_LO_A);
  end

  // Cipher stage handshake: advance whenever the output register frees up
  always_comb begin
    s1_move   = s1_v_q && (!out_v_q || out_ready_i);
    s1_letter = s1_v_q && !s1_end_q;
    pad_last  = (LEN_W'(s1_pos_q) + LEN_W'(1)) == len;
    s1_done   = !s1_end_q || s1_bare_q || pad_last;
    in_ready_o  = !s1_v_q || (s1_move && s1_done);
    accept      = in_valid_i && in_ready_o;
    take_letter = accept && !end_of_text_i && is_letter;
    mem_we      = s1_move && !s1_end_q;
  end

  always_comb begin
    pos_d   = pos_q;
    first_d = first_q;
    if (accept) begin
      priority if (end_of_text_i) begin
        pos_d   = '0;
        first_d = 1'b1;
      end else if (is_letter) begin
        pos_d   = blk_end ? '0 : AW'(pos_inc);
        first_d = blk_end ? 1'b0 : first_eff;
      end else begin
        pos_d   = pos_eff;
        first_d = first_eff;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      first_q <= 1'b1;
    end else begin
      pos_q   <= pos_d;
      first_q <= first_d;
    end
  end

  // --------------------------------------------------------------------------
  // Cipher stage register
  // --------------------------------------------------------------------------
  always_comb begin
    s1_v_d     = s1_v_q;
    s1_end_d   = s1_end_q;
    s1_bare_d  = s1_bare_q;
    s1_pos_d   = s1_pos_q;
    s1_first_d = s1_first_q;
    s1_p_d     = s1_p_q;
    s1_fwd_d   = s1_fwd_q;
    priority if (accept && (end_of_text_i || is_letter)) begin
      s1_v_d     = 1'b1;
      s1_end_d   = end_of_text_i;
      s1_bare_d  = (pos_eff == '0) && !first_eff;
      s1_pos_d   = pos_eff;
      s1_first_d = first_eff;
      s1_p_d     = plain;
      // the entry is written back this same edge: take the new value instead
      s1_fwd_d   = mem_we && (s1_pos_q == pos_eff);
    end else if (s1_move && s1_done) begin
      s1_v_d = 1'b0;
    end else if (s1_move) begin
      // step to the next pad position
      s1_pos_d = AW'(LEN_W'(s1_pos_q) + LEN_W'(1));
    end else begin
      // hold the stage
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else begin
      s1_v_q <= s1_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_end_q   <= s1_end_d;
    s1_bare_q  <= s1_bare_d;
    s1_pos_q   <= s1_pos_d;
    s1_first_q <= s1_first_d;
    s1_p_q     <= s1_p_d;
    s1_fwd_q   <= s1_fwd_d;
  end

  // --------------------------------------------------------------------------
  // Chain memory: read at accept, write back when the letter leaves
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (take_letter) begin
      rdata_q <= chain_mem[pos_eff];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      chain_mem[s1_pos_q] <= cipher;
      lastc_q             <= cipher;
    end
  end

  always_comb begin
    req.slot   = SLOT_IDX_W'(s1_pos_q);
    req.plain  = s1_p_q;
    req.use_iv = s1_first_q;
    req.chain  = s1_fwd_q ? lastc_q : rdata_q;
  end

  cve_cipher_unit u_cipher (
    .req_i         (req),
    .key_letters_i (key_q),
    .iv_letters_i  (iv_q),
    .cipher_o      (cipher)
  );

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_comb begin
    out_v_d    = out_v_q;
    out_char_d = out_char_q;
    out_cv_d   = out_cv_q;
    out_pad_d  = out_pad_q;
    out_last_d = out_last_q;
    if (s1_move) begin
      out_v_d = 1'b1;
      priority if (s1_letter) begin
        out_char_d = CHAR_LO_A + CHAR_W'(cipher);
        out_cv_d   = 1'b1;
        out_pad_d  = 1'b0;
        out_last_d = 1'b0;
      end else if (s1_bare_q) begin
        out_char_d = CHAR_NONE;
        out_cv_d   = 1'b0;
        out_pad_d  = 1'b0;
        out_last_d = 1'b1;
      end else begin
        out_char_d = CHAR_PAD;
        out_cv_d   = 1'b1;
        out_pad_d  = 1'b1;
        out_last_d = pad_last;
      end
    end else if (out_ready_i) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_char_q <= out_char_d;
    out_cv_q   <= out_cv_d;
    out_pad_q  <= out_pad_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o  = out_v_q;
  assign out_char_o   = out_char_q;
  assign char_valid_o = out_cv_q;
  assign is_pad_o     = out_pad_q;
  assign last_o       = out_last_q;

endmodule

`default_nettype wire

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Regression for cbc_vigenere_encrypt_top. A cycle-free cipher predictor runs
// alongside the block: every accepted input beat updates the predicted state
// and queues the ciphertext, pad and end-marker beats it must cause. A
// checker compares each accepted output beat against the oldest queued one.
// Directed tests cover reset defaults, chain fill, key length extremes, pads,
// bare end markers and a mid-block key length drop. They are followed by
// random messages under random configuration with bursty idling on both
// channels.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

  import cve_pkg::*;

  // One output beat as seen on the result channel.
  typedef struct packed {
    logic [7:0] ch;
    logic       cv;
    logic       pad;
    logic       last;
  } cipher_beat_t;

  localparam int unsigned MAX_SHOWN = 10;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_byte;
  logic       end_of_text;

  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_char;
  logic       char_valid;
  logic       is_pad;
  logic       last;

  // Predicted block state and configuration.
  logic [3:0]  cfg_len;
  logic [59:0] cfg_key;
  logic [59:0] cfg_iv;
  int unsigned blk_pos;
  logic        in_first_block;
  logic [4:0]  chain_mem [12];

  cipher_beat_t cipher_q[$];
  int unsigned  fail_count  = 0;
  int unsigned  items_sent  = 0;
  logic         idle_on     = 1'b1;

  cipher_beat_t got_beat;
  cipher_beat_t want_beat;
  int unsigned  ready_hold  = 0;

  cbc_vigenere_encrypt_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .in_byte_i     (in_byte),
    .end_of_text_i (end_of_text),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .out_char_o    (out_char),
    .char_valid_o  (char_valid),
    .is_pad_o      (is_pad),
    .last_o        (last)
  );

  always #10 clk_i = ~clk_i;

  // Hard stop in case the block hangs.
  initial begin
    #(20_000_000);
    $display("cbc_vigenere_encrypt_top regression: fail");
    $finish;
  end

  // Letter j of a packed 12-slot register, reduced mod 26.
  function automatic logic [4:0] slot_of(input logic [59:0] packed_v, input int unsigned j);
    logic [4:0] raw;
    raw = packed_v[5*j +: 5];
    return (raw >= 5'd26) ? raw - 5'd26 : raw;
  endfunction

  // Advance the predicted state by one accepted beat and queue its results.
  task automatic predict_cipher(input logic [7:0] b, input logic eot);
    int unsigned  len;
    int unsigned  j;
    int unsigned  sum;
    logic [7:0]   c;
    logic [4:0]   chain_v;
    cipher_beat_t beat;
    len = (cfg_len == 4'd0) ? 1 : ((cfg_len > 4'd12) ? 12 : cfg_len);
    // A shortened key can leave the position past the end: close the block.
    if (blk_pos >= len) begin
      blk_pos        = 0;
      in_first_block = 1'b0;
    end
    if (eot) begin
      if (blk_pos == 0 && !in_first_block) begin
        // Message ended on a block boundary: bare end marker only.
        beat = '{ch: CHAR_NONE, cv: 1'b0, pad: 1'b0, last: 1'b1};
        cipher_q.push_back(beat);
      end else begin
        for (j = blk_pos; j < len; j++) begin
          beat = '{ch: CHAR_PAD, cv: 1'b1, pad: 1'b1, last: (j + 1 == len)};
          cipher_q.push_back(beat);
        end
      end
      blk_pos        = 0;
      in_first_block = 1'b1;
    end else begin
      c = b;
      if (c >= CHAR_UP_A && c <= CHAR_UP_Z) c = c + CASE_GAP;
      if (c >= CHAR_LO_A && c <= CHAR_LO_Z) begin
        chain_v = in_first_block ? slot_of(cfg_iv, blk_pos) : chain_mem[blk_pos];
        sum = (c - CHAR_LO_A) + slot_of(cfg_key, blk_pos) + chain_v;
        sum = sum % 26;
        chain_mem[blk_pos] = sum[4:0];
        beat = '{ch: CHAR_LO_A + sum[7:0], cv: 1'b1, pad: 1'b0, last: 1'b0};
        cipher_q.push_back(beat);
        blk_pos++;
        if (blk_pos >= len) begin
          blk_pos        = 0;
          in_first_block = 1'b0;
        end
      end
    end
  endtask

  // Present one beat, wait for the handshake, then predict it.
  task automatic send_beat(input logic [7:0] b, input logic eot);
    @(negedge clk_i);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
    end
    in_valid    <= 1'b1;
    in_byte     <= b;
    end_of_text <= eot;
    do @(posedge clk_i); while (!in_ready);
    items_sent++;
    predict_cipher(b, eot);
  endtask

  // Send n letters of random case, with stray bytes mixed in.
  task automatic send_text(input int unsigned n);
    int unsigned i;
    for (i = 0; i < n; i++) begin
      if ($urandom_range(0, 6) == 0) send_beat(8'($urandom_range(0, 255)), 1'b0);
      if ($urandom_range(0, 1) == 0) send_beat(CHAR_UP_A + 8'($urandom_range(0, 25)), 1'b0);
      else send_beat(CHAR_LO_A + 8'($urandom_range(0, 25)), 1'b0);
    end
  endtask

  // Drop valid and wait until every predicted beat has come out.
  task automatic drain_block();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (cipher_q.size() != 0) @(posedge clk_i);
    // Dropped bytes leave nothing to wait for: give the pipeline time to empty.
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [59:0] data);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_KEY_LENGTH:  cfg_len = data[3:0];
      REG_KEY_LETTERS: cfg_key = data;
      REG_IV_LETTERS:  cfg_iv  = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [59:0] rand_bits60();
    return 60'({$urandom, $urandom});
  endfunction

  function automatic logic [59:0] pick_letters();
    int unsigned r;
    r = $urandom_range(0, 7);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return rand_bits60();
  endfunction

  // Mostly legal lengths, sometimes zero or above the maximum.
  function automatic logic [59:0] pick_key_length();
    int unsigned r;
    logic [59:0] v;
    r = $urandom_range(0, 9);
    v = rand_bits60();
    case (r)
      0:       v[3:0] = 4'd0;
      1:       v[3:0] = 4'($urandom_range(13, 15));
      2:       v[3:0] = 4'd12;
      3:       v[3:0] = 4'd1;
      default: v[3:0] = 4'($urandom_range(1, 12));
    endcase
    return v;
  endfunction

  // Result channel: bursts of back-pressure between runs of ready.
  always @(negedge clk_i) begin
    if (ready_hold == 0) begin
      if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ready  <= 1'b0;
        ready_hold = $urandom_range(0, 13);
      end else begin
        out_ready  <= 1'b1;
        ready_hold = $urandom_range(1, 24);
      end
    end else begin
      ready_hold--;
    end
  end

  // Compare every accepted output beat with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      got_beat = '{ch: out_char, cv: char_valid, pad: is_pad, last: last};
      if (cipher_q.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_SHOWN)
          $display("unexpected beat: char=%h valid=%b pad=%b last=%b",
                   got_beat.ch, got_beat.cv, got_beat.pad, got_beat.last);
      end else begin
        want_beat = cipher_q.pop_front();
        if (got_beat.ch !== want_beat.ch || got_beat.cv !== want_beat.cv ||
            got_beat.pad !== want_beat.pad || got_beat.last !== want_beat.last) begin
          fail_count++;
          if (fail_count <= MAX_SHOWN)
            $display("mismatch: exp char=%h valid=%b pad=%b last=%b, got char=%h valid=%b pad=%b last=%b",
                     want_beat.ch, want_beat.cv, want_beat.pad, want_beat.last,
                     got_beat.ch, got_beat.cv, got_beat.pad, got_beat.last);
        end
      end
    end
  end

  // Defaults after reset: one-letter blocks, zero key and IV.
  task automatic test_reset_defaults();
    send_beat("a", 1'b0);
    send_beat("Z", 1'b0);
    send_beat("!", 1'b0);
    send_beat(8'h00, 1'b1);  // ends on a boundary: bare marker
    send_beat(8'h00, 1'b1);  // empty message: one pad
    drain_block();
  endtask

  // Full-length first block writes every chain entry.
  task automatic test_fill_chain();
    int unsigned i;
    write_reg(REG_KEY_LENGTH, 60'd12);
    write_reg(REG_KEY_LETTERS, rand_bits60());
    write_reg(REG_IV_LETTERS, rand_bits60());
    for (i = 0; i < 12; i++) send_beat(CHAR_LO_A + 8'($urandom_range(0, 25)), 1'b0);
    send_beat("q", 1'b1);
    drain_block();
  endtask

  // Key length zero and above the maximum, extreme key/IV, stray bytes.
  task automatic test_length_extremes();
    write_reg(REG_KEY_LENGTH, 60'd0);
    write_reg(REG_KEY_LETTERS, '1);
    write_reg(REG_IV_LETTERS, '0);
    send_beat("z", 1'b0);
    send_beat(8'h00, 1'b1);
    drain_block();
    write_reg(REG_KEY_LENGTH, {56'hFFFFFFFFFFFFFF, 4'd15});
    write_reg(REG_IV_LETTERS, '1);
    send_beat(8'hFF, 1'b1);  // empty message under saturated length
    drain_block();
    write_reg(REG_KEY_LENGTH, 60'd13);
    send_beat("A", 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'h40, 1'b0);
    send_beat(8'h5B, 1'b0);
    send_beat(8'h60, 1'b0);
    send_beat(8'h7B, 1'b0);
    send_beat("Z", 1'b0);
    send_beat("z", 1'b1);    // letter byte on an end beat is ignored
    drain_block();
  endtask

  // Lower the key length while a block is half full.
  task automatic test_shrink_midblock();
    write_reg(REG_KEY_LENGTH, 60'd8);
    write_reg(REG_KEY_LETTERS, rand_bits60());
    send_text(5);
    drain_block();
    write_reg(REG_KEY_LENGTH, 60'd3);
    send_text(2);
    send_beat(8'h00, 1'b1);
    drain_block();
  endtask

  // Random messages under random settings until the item budget is spent.
  task automatic test_random_messages();
    int unsigned n_msgs;
    int unsigned n;
    while (items_sent < 460) begin
      drain_block();
      write_reg(REG_KEY_LENGTH, pick_key_length());
      if ($urandom_range(0, 1) == 0) write_reg(REG_KEY_LETTERS, pick_letters());
      if ($urandom_range(0, 1) == 0) write_reg(REG_IV_LETTERS, pick_letters());
      n_msgs = $urandom_range(1, 4);
      repeat (n_msgs) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 14);
        send_text(n);
        if ($urandom_range(0, 7) == 0) begin
          // change the block length in the middle of a message
          drain_block();
          write_reg(REG_KEY_LENGTH, pick_key_length());
          send_text($urandom_range(1, 10));
        end
        // an occasional message runs on into the next one
        if ($urandom_range(0, 15) != 0) send_beat(8'($urandom_range(0, 255)), 1'b1);
      end
      // hold both channels busy for the last stretch
      if (items_sent >= 400) idle_on = 1'b0;
    end
    send_beat(8'h00, 1'b1);
  endtask

  initial begin
    rst_ni         = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = REG_KEY_LENGTH;
    cfg_data       = '0;
    in_valid       = 1'b0;
    in_byte        = 8'h00;
    end_of_text    = 1'b0;
    out_ready      = 1'b0;
    cfg_len        = 4'd1;
    cfg_key        = '0;
    cfg_iv         = '0;
    blk_pos        = 0;
    in_first_block = 1'b1;
    for (int i = 0; i < 12; i++) chain_mem[i] = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_defaults();
    test_fill_chain();
    test_length_extremes();
    test_shrink_midblock();
    test_random_messages();

    drain_block();
    repeat (16) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("cbc_vigenere_encrypt_top regression: pass");
    end else begin
      $display("cbc_vigenere_encrypt_top regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
